// ----- hdl/limit_order_matcher_top_defines.svh -----
// Assertion shorthands for the limit order matcher.
// They rely on clk and rst_n being visible where they are used.
`ifndef LIMIT_ORDER_MATCHER_TOP_DEFINES_SVH
`define LIMIT_ORDER_MATCHER_TOP_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define LOM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever trig is high, cond holds in the same cycle.
`define LOM_ASSERT_IMPLIES(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

`endif

// ----- hdl/lom_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types, widths and codes for the limit order matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lom_pkg;

  localparam int BOOK_DEPTH_DEF = 16;
  localparam int USER_COUNT_DEF = 256;

  localparam int USER_W      = 8;
  localparam int PRICE_BITS  = 16;
  localparam int VOLUME_BITS = 16;
  localparam int COST_W      = PRICE_BITS + VOLUME_BITS;
  localparam int AMT_W       = 40;
  localparam int RUB_W       = 48;
  localparam int USD_W       = 32;
  localparam int NUM_W       = 5;
  localparam int MAX_RESULTS = 34;
  localparam int TC_W        = $clog2(MAX_RESULTS);

  localparam logic SIDE_SELL  = 1'b0;
  localparam logic SIDE_BUY   = 1'b1;
  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_ACK   = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_FULL    = 1'b1;

  typedef struct packed {
    logic [USER_W-1:0]      user;
    logic [VOLUME_BITS-1:0] vol;
    logic [PRICE_BITS-1:0]  price;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_APPEND, S_BSTART, S_BSCAN, S_SSTART, S_SSCAN,
    S_CALC, S_MUL, S_RD_S, S_WR_S, S_RD_B, S_WR_B, S_EMIT, S_REMOVE, S_NEXT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clr_step;
    logic take_in;
    logic do_append;
    logic binit;
    logic bscan_step;
    logic sinit;
    logic sscan_step;
    logic calc_min;
    logic calc_mul;
    logic rd_seller;
    logic wr_seller;
    logic rd_buyer;
    logic wr_buyer;
    logic rd_sub;
    logic load_trade;
    logic do_remove;
    logic load_ack;
  } lom_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic book_full;
    logic other_empty;
    logic bscan_done;
    logic have_buy;
    logic sscan_done;
    logic cross_ok;
    logic sell_empty;
    logic room;
    logic out_free;
  } lom_sts_t;

endpackage

`default_nettype wire

// ----- hdl/limit_order_matcher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_matcher_top
// Limit order book matching engine: order append, price-time matching, acks.
// ----------------------------------------------------------------------------
// Each accepted order yields zero or more trade beats followed by one
// acknowledgment beat (out_last high). A full book or an empty opposite book
// skips matching: the order goes straight to the ack phase, which reads the
// trader's balances and then registers the ack. Each match round runs two
// linear scans of the books, one per entry per cycle, then a multiply and a
// read-modify-write of both traders' balances in the balance memories. Trade
// and ack beats wait while the output is stalled. After reset the balance
// memories are swept to zero, one entry per cycle, before the first order is
// taken. The next order is taken as soon as the ack is registered.
`default_nettype none

module limit_order_matcher_top #(
  parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF,
  parameter int USER_COUNT = lom_pkg::USER_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_req_type,
  input  wire logic [lom_pkg::USER_W-1:0]       in_trader,
  input  wire logic [15:0]                      in_quantity,
  input  wire logic [15:0]                      in_limit_price,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic [lom_pkg::USER_W-1:0]            out_seller_user,
  output logic [lom_pkg::USER_W-1:0]            out_buyer_user,
  output logic [lom_pkg::AMT_W-1:0]             out_trade_amount,
  output logic [lom_pkg::PRICE_BITS-1:0]        out_trade_price,
  output logic [lom_pkg::NUM_W-1:0]             out_order_number,
  output logic                                  out_status,
  output logic signed [lom_pkg::RUB_W-1:0]      out_rub_balance,
  output logic signed [lom_pkg::USD_W-1:0]      out_usd_balance,
  output logic [lom_pkg::PRICE_BITS-1:0]        out_session_low,
  output logic [lom_pkg::PRICE_BITS-1:0]        out_session_high,
  output logic                                  out_last
);

  lom_pkg::lom_cmd_t cmd;
  lom_pkg::lom_sts_t sts;

  lom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lom_datapath #(
    .BOOK_DEPTH (BOOK_DEPTH),
    .USER_COUNT (USER_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_trader        (in_trader),
    .in_quantity      (in_quantity),
    .in_limit_price   (in_limit_price),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_seller_user  (out_seller_user),
    .out_buyer_user   (out_buyer_user),
    .out_trade_amount (out_trade_amount),
    .out_trade_price  (out_trade_price),
    .out_order_number (out_order_number),
    .out_status       (out_status),
    .out_rub_balance  (out_rub_balance),
    .out_usd_balance  (out_usd_balance),
    .out_session_low  (out_session_low),
    .out_session_high (out_session_high),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ----- hdl/lom_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_ctrl
// Sequencer for clearing, order append, match rounds and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module lom_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lom_pkg::lom_sts_t sts,
  output lom_pkg::lom_cmd_t      cmd
);

  lom_pkg::state_t state_r, state_nxt;

  // The ack read and ack delivery steps have no state_t encoding of their own:
  // they are tracked by the flags ackph_r and ack_r.
  logic ack_r, ack_nxt;   // in ack phase: 0 = read balances, 1 = deliver
  logic ackph_r, ackph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lom_pkg::S_CLEAR;
      ack_r   <= 1'b0;
      ackph_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ack_r   <= ack_nxt;
      ackph_r <= ackph_nxt;
    end
  end

  // ackph_r marks the acknowledgment phase, entered from several states;
  // state_r then stays parked at S_NEXT.
  always_comb begin
    state_nxt = state_r;
    ack_nxt   = ack_r;
    ackph_nxt = ackph_r;
    if (ackph_r) begin
      if (!ack_r) begin
        ack_nxt = 1'b1;
      end else if (sts.out_free) begin
        ack_nxt   = 1'b0;
        ackph_nxt = 1'b0;
        state_nxt = lom_pkg::S_IDLE;
      end
    end else begin
      case (state_r)
        lom_pkg::S_CLEAR:  if (sts.clr_done) state_nxt = lom_pkg::S_IDLE;
        lom_pkg::S_IDLE:   if (in_valid) state_nxt = lom_pkg::S_APPEND;
        lom_pkg::S_APPEND: begin
          if (sts.book_full || sts.other_empty) begin
            ackph_nxt = 1'b1;
            state_nxt = lom_pkg::S_NEXT;
          end else begin
            state_nxt = lom_pkg::S_BSTART;
          end
        end
        lom_pkg::S_BSTART: state_nxt = lom_pkg::S_BSCAN;
        lom_pkg::S_BSCAN: begin
          if (sts.bscan_done) begin
            if (sts.have_buy) begin
              state_nxt = lom_pkg::S_SSTART;
            end else begin
              ackph_nxt = 1'b1;
              state_nxt = lom_pkg::S_NEXT;
            end
          end
        end
        lom_pkg::S_SSTART: state_nxt = lom_pkg::S_SSCAN;
        lom_pkg::S_SSCAN: begin
          if (sts.sscan_done) begin
            if (sts.cross_ok) begin
              state_nxt = lom_pkg::S_CALC;
            end else begin
              ackph_nxt = 1'b1;
              state_nxt = lom_pkg::S_NEXT;
            end
          end
        end
        lom_pkg::S_CALC:   state_nxt = lom_pkg::S_MUL;
        lom_pkg::S_MUL:    state_nxt = lom_pkg::S_RD_S;
        lom_pkg::S_RD_S:   state_nxt = lom_pkg::S_WR_S;
        lom_pkg::S_WR_S:   state_nxt = lom_pkg::S_RD_B;
        lom_pkg::S_RD_B:   state_nxt = lom_pkg::S_WR_B;
        lom_pkg::S_WR_B:   state_nxt = lom_pkg::S_EMIT;
        lom_pkg::S_EMIT:   if (sts.out_free) state_nxt = lom_pkg::S_REMOVE;
        lom_pkg::S_REMOVE: state_nxt = lom_pkg::S_NEXT;
        lom_pkg::S_NEXT: begin
          if (sts.sell_empty || !sts.room) ackph_nxt = 1'b1;
          else state_nxt = lom_pkg::S_BSTART;
        end
        default: state_nxt = lom_pkg::S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    if (ackph_r) begin
      cmd.rd_sub   = !ack_r;
      cmd.load_ack = ack_r && sts.out_free;
    end else begin
      case (state_r)
        lom_pkg::S_CLEAR:  cmd.clr_step = 1'b1;
        lom_pkg::S_IDLE: begin
          in_ready    = 1'b1;
          cmd.take_in = in_valid;
        end
        lom_pkg::S_APPEND: cmd.do_append  = 1'b1;
        lom_pkg::S_BSTART: cmd.binit      = 1'b1;
        lom_pkg::S_BSCAN:  cmd.bscan_step = 1'b1;
        lom_pkg::S_SSTART: cmd.sinit      = 1'b1;
        lom_pkg::S_SSCAN:  cmd.sscan_step = 1'b1;
        lom_pkg::S_CALC:   cmd.calc_min   = 1'b1;
        lom_pkg::S_MUL:    cmd.calc_mul   = 1'b1;
        lom_pkg::S_RD_S:   cmd.rd_seller  = 1'b1;
        lom_pkg::S_WR_S:   cmd.wr_seller  = 1'b1;
        lom_pkg::S_RD_B:   cmd.rd_buyer   = 1'b1;
        lom_pkg::S_WR_B:   cmd.wr_buyer   = 1'b1;
        lom_pkg::S_EMIT:   cmd.load_trade = sts.out_free;
        lom_pkg::S_REMOVE: cmd.do_remove  = 1'b1;
        lom_pkg::S_NEXT:   cmd            = '0;
        default:           cmd            = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lom_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_datapath
// Order books, best-price scan, balance memories, quotes and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "limit_order_matcher_top_defines.svh"

module lom_datapath #(
  parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF,
  parameter int USER_COUNT = lom_pkg::USER_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire lom_pkg::lom_cmd_t                cmd,
  output lom_pkg::lom_sts_t                     sts,
  input  wire logic                             in_req_type,
  input  wire logic [lom_pkg::USER_W-1:0]       in_trader,
  input  wire logic [15:0]                      in_quantity,
  input  wire logic [15:0]                      in_limit_price,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic [lom_pkg::USER_W-1:0]            out_seller_user,
  output logic [lom_pkg::USER_W-1:0]            out_buyer_user,
  output logic [lom_pkg::AMT_W-1:0]             out_trade_amount,
  output logic [lom_pkg::PRICE_BITS-1:0]        out_trade_price,
  output logic [lom_pkg::NUM_W-1:0]             out_order_number,
  output logic                                  out_status,
  output logic signed [lom_pkg::RUB_W-1:0]      out_rub_balance,
  output logic signed [lom_pkg::USD_W-1:0]      out_usd_balance,
  output logic [lom_pkg::PRICE_BITS-1:0]        out_session_low,
  output logic [lom_pkg::PRICE_BITS-1:0]        out_session_high,
  output logic                                  out_last
);

  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int UW = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
  localparam int PB = lom_pkg::PRICE_BITS;
  localparam int VB = lom_pkg::VOLUME_BITS;

  // trader modulo USER_COUNT by restoring subtraction, eight steps
  function automatic logic [UW-1:0] user_index(input logic [lom_pkg::USER_W-1:0] u);
    logic [31:0] rem;
    rem = 32'(u);
    for (int k = lom_pkg::USER_W - 1; k >= 0; k--) begin
      if (rem >= (32'(USER_COUNT) << k)) rem = rem - (32'(USER_COUNT) << k);
    end
    return rem[UW-1:0];
  endfunction

  lom_pkg::entry_t buy_r  [BOOK_DEPTH];
  lom_pkg::entry_t sell_r [BOOK_DEPTH];
  logic [CW-1:0] buy_cnt_r, sell_cnt_r;

  // latched order
  logic                      side_r;
  logic [lom_pkg::USER_W-1:0] user_r;
  logic [VB-1:0]             qty_r;
  logic [PB-1:0]             price_r;
  logic [CW-1:0]             number_r;
  logic                      status_r;

  // scan state
  logic [CW-1:0]              idx_r;
  logic                       haveb_r, haves_r;
  logic [PB-1:0]              bestp_r, minp_r;
  logic [IW-1:0]              bi_r, si_r;
  logic [lom_pkg::USER_W-1:0] buser_r, suser_r;
  logic [VB-1:0]              bvol_r, svol_r, v_r;
  logic [lom_pkg::COST_W-1:0] cost_r;
  logic [UW-1:0]              su_r, bu_r, ui_r;
  logic [lom_pkg::TC_W-1:0]   tcnt_r;

  // quotes
  logic [PB-1:0]             open_r, low_r, high_r;
  logic [lom_pkg::AMT_W-1:0] total_r;

  // balance memories
  logic [lom_pkg::RUB_W-1:0] rub_mem [USER_COUNT];
  logic [lom_pkg::USD_W-1:0] usd_mem [USER_COUNT];
  logic [lom_pkg::RUB_W-1:0] rub_rd_r, rub_wd;
  logic [lom_pkg::USD_W-1:0] usd_rd_r, usd_wd;
  logic [UW-1:0]             clr_idx_r, mem_ra, mem_wa;
  logic                      mem_re, mem_we;

  logic            own_full, bscan_done, sscan_done;
  lom_pkg::entry_t bcur, scur;
  logic            brem, srem;
  logic [CW-1:0]   own_cnt;

  logic out_valid_r;

  assign own_cnt    = (side_r == lom_pkg::SIDE_BUY) ? buy_cnt_r : sell_cnt_r;
  assign own_full   = own_cnt >= CW'(BOOK_DEPTH);
  assign bscan_done = idx_r >= buy_cnt_r;
  assign sscan_done = idx_r >= sell_cnt_r;
  assign bcur       = buy_r[idx_r[IW-1:0]];
  assign scur       = sell_r[idx_r[IW-1:0]];
  assign brem       = (bvol_r == '0);
  assign srem       = (svol_r == '0);

  always_comb begin
    sts             = '0;
    sts.clr_done    = (clr_idx_r == UW'(USER_COUNT - 1));
    sts.book_full   = own_full;
    sts.other_empty = (side_r == lom_pkg::SIDE_BUY) ? (sell_cnt_r == '0) : (buy_cnt_r == '0);
    sts.bscan_done  = bscan_done;
    sts.have_buy    = haveb_r;
    sts.sscan_done  = sscan_done;
    sts.cross_ok    = haves_r && !(minp_r > bestp_r);
    sts.sell_empty  = (sell_cnt_r == '0);
    sts.room        = (tcnt_r < lom_pkg::TC_W'(lom_pkg::MAX_RESULTS - 1));
    sts.out_free    = !out_valid_r || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buy_cnt_r   <= '0;
      sell_cnt_r  <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      open_r      <= '0;
      low_r       <= '0;
      high_r      <= '0;
      total_r     <= '0;
    end else begin
      if (cmd.clr_step) clr_idx_r <= clr_idx_r + UW'(1);
      if (cmd.do_append && !own_full) begin
        if (side_r == lom_pkg::SIDE_BUY) buy_cnt_r <= buy_cnt_r + CW'(1);
        else sell_cnt_r <= sell_cnt_r + CW'(1);
      end
      if (cmd.do_remove) begin
        if (brem) buy_cnt_r <= buy_cnt_r - CW'(1);
        if (srem) sell_cnt_r <= sell_cnt_r - CW'(1);
      end
      if (cmd.load_trade) begin
        if (open_r == '0) begin
          open_r  <= bestp_r;
          low_r   <= bestp_r;
          high_r  <= bestp_r;
          total_r <= lom_pkg::AMT_W'(v_r);
        end else begin
          if (bestp_r < low_r) low_r <= bestp_r;
          if (bestp_r > high_r) high_r <= bestp_r;
          total_r <= total_r + lom_pkg::AMT_W'(v_r);
        end
      end
      if (cmd.load_trade || cmd.load_ack) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // books: append at count, volume write-back, shift-down removal
  always_ff @(posedge clk) begin
    if (cmd.do_append && !own_full) begin
      if (side_r == lom_pkg::SIDE_BUY) begin
        buy_r[buy_cnt_r[IW-1:0]] <= '{user: user_r, vol: qty_r, price: price_r};
      end else begin
        sell_r[sell_cnt_r[IW-1:0]] <= '{user: user_r, vol: qty_r, price: price_r};
      end
    end
    if (cmd.load_trade) begin
      buy_r[bi_r].vol  <= bvol_r - v_r;
      sell_r[si_r].vol <= svol_r - v_r;
    end
    if (cmd.do_remove) begin
      for (int j = 0; j < BOOK_DEPTH - 1; j++) begin
        if (brem && IW'(j) >= bi_r) buy_r[j] <= buy_r[j+1];
        if (srem && IW'(j) >= si_r) sell_r[j] <= sell_r[j+1];
      end
    end
  end

  // scan, trade arithmetic and order latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      haveb_r <= 1'b0;
      haves_r <= 1'b0;
      tcnt_r  <= '0;
    end else begin
      if (cmd.take_in) begin
        side_r  <= in_req_type;
        user_r  <= in_trader;
        qty_r   <= VB'(in_quantity);
        price_r <= PB'(in_limit_price);
        ui_r    <= user_index(in_trader);
      end
      if (cmd.do_append) begin
        number_r <= own_cnt;
        status_r <= own_full ? lom_pkg::ST_FULL : lom_pkg::ST_OK;
        tcnt_r   <= '0;
      end
      if (cmd.binit) begin
        idx_r   <= '0;
        haveb_r <= 1'b0;
        bestp_r <= '0;
      end
      if (cmd.bscan_step && !bscan_done) begin
        if (bcur.price > bestp_r) begin
          bestp_r <= bcur.price;
          bi_r    <= idx_r[IW-1:0];
          buser_r <= bcur.user;
          bvol_r  <= bcur.vol;
          haveb_r <= 1'b1;
        end
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.sinit) begin
        idx_r   <= '0;
        haves_r <= 1'b0;
      end
      if (cmd.sscan_step && !sscan_done) begin
        if (scur.user != buser_r && (!haves_r || scur.price < minp_r)) begin
          minp_r  <= scur.price;
          si_r    <= idx_r[IW-1:0];
          suser_r <= scur.user;
          svol_r  <= scur.vol;
          haves_r <= 1'b1;
        end
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.calc_min) begin
        v_r  <= (bvol_r < svol_r) ? bvol_r : svol_r;
        su_r <= user_index(suser_r);
        bu_r <= user_index(buser_r);
      end
      if (cmd.calc_mul) cost_r <= lom_pkg::COST_W'(v_r) * lom_pkg::COST_W'(bestp_r);
      if (cmd.load_trade) begin
        bvol_r <= bvol_r - v_r;
        svol_r <= svol_r - v_r;
        tcnt_r <= tcnt_r + lom_pkg::TC_W'(1);
      end
    end
  end

  // balance memory port control
  always_comb begin
    mem_re = cmd.rd_seller || cmd.rd_buyer || cmd.rd_sub;
    mem_we = cmd.clr_step || cmd.wr_seller || cmd.wr_buyer;
    mem_ra = cmd.rd_seller ? su_r : (cmd.rd_buyer ? bu_r : ui_r);
    mem_wa = cmd.clr_step ? clr_idx_r : (cmd.wr_seller ? su_r : bu_r);
    rub_wd = '0;
    usd_wd = '0;
    if (cmd.wr_seller) begin
      rub_wd = rub_rd_r + lom_pkg::RUB_W'(cost_r);
      usd_wd = usd_rd_r - lom_pkg::USD_W'(v_r);
    end else if (cmd.wr_buyer) begin
      rub_wd = rub_rd_r - lom_pkg::RUB_W'(cost_r);
      usd_wd = usd_rd_r + lom_pkg::USD_W'(v_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rub_mem[mem_wa] <= rub_wd;
      usd_mem[mem_wa] <= usd_wd;
    end
    if (mem_re) begin
      rub_rd_r <= rub_mem[mem_ra];
      usd_rd_r <= usd_mem[mem_ra];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_trade) begin
      out_kind         <= lom_pkg::KIND_TRADE;
      out_seller_user  <= suser_r;
      out_buyer_user   <= buser_r;
      out_trade_amount <= lom_pkg::AMT_W'(v_r);
      out_trade_price  <= bestp_r;
      out_order_number <= '0;
      out_status       <= lom_pkg::ST_OK;
      out_rub_balance  <= '0;
      out_usd_balance  <= '0;
      out_session_low  <= '0;
      out_session_high <= '0;
      out_last         <= 1'b0;
    end else if (cmd.load_ack) begin
      out_kind         <= lom_pkg::KIND_ACK;
      out_seller_user  <= '0;
      out_buyer_user   <= '0;
      out_trade_amount <= total_r;
      out_trade_price  <= open_r;
      out_order_number <= lom_pkg::NUM_W'(number_r);
      out_status       <= status_r;
      out_rub_balance  <= rub_rd_r;
      out_usd_balance  <= usd_rd_r;
      out_session_low  <= low_r;
      out_session_high <= high_r;
      out_last         <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  `LOM_ASSERT_ALWAYS(a_buy_cnt_max, buy_cnt_r <= CW'(BOOK_DEPTH), "buy count above depth")
  `LOM_ASSERT_ALWAYS(a_sell_cnt_max, sell_cnt_r <= CW'(BOOK_DEPTH), "sell count above depth")
  `LOM_ASSERT_IMPLIES(a_load_free, cmd.load_trade || cmd.load_ack, sts.out_free, "beat lost")
  `LOM_ASSERT_IMPLIES(a_trade_cross, cmd.calc_min, haveb_r && sts.cross_ok, "no price cross")
  `LOM_ASSERT_IMPLIES(a_remove_nonempty, cmd.do_remove && srem, sell_cnt_r != '0, "empty sell")

endmodule

`default_nettype wire

// ----- sim/tb_limit_order_matcher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_limit_order_matcher_top
// Self-checking bench for the limit order matcher. A scoreboard keeps its
// own copy of both books, the balance tables and the session quotes. For
// every accepted order it predicts the trade beats and the ack. Each output
// beat is then checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_limit_order_matcher_top;

  localparam int DEPTH     = 16;
  localparam int USERS     = 256;
  localparam int MAX_CYCLE = 5000000;
  localparam int N_RANDOM  = 244;
  localparam int TAIL      = 100;

  typedef struct packed {
    logic [lom_pkg::USER_W-1:0]      user;
    logic [lom_pkg::VOLUME_BITS-1:0] vol;
    logic [lom_pkg::PRICE_BITS-1:0]  price;
  } order_t;

  typedef struct packed {
    logic                           kind;
    logic [lom_pkg::USER_W-1:0]     seller;
    logic [lom_pkg::USER_W-1:0]     buyer;
    logic [lom_pkg::AMT_W-1:0]      amount;
    logic [lom_pkg::PRICE_BITS-1:0] price;
    logic [lom_pkg::NUM_W-1:0]      number;
    logic                           status;
    logic [lom_pkg::RUB_W-1:0]      rub;
    logic [lom_pkg::USD_W-1:0]      usd;
    logic [lom_pkg::PRICE_BITS-1:0] low;
    logic [lom_pkg::PRICE_BITS-1:0] high;
    logic                           last;
  } beat_t;

  class match_scoreboard;
    order_t         sells[DEPTH];
    order_t         buys[DEPTH];
    int             n_sell;
    int             n_buy;
    logic [lom_pkg::RUB_W-1:0] rub_tbl[USERS];
    logic [lom_pkg::USD_W-1:0] usd_tbl[USERS];
    logic [lom_pkg::PRICE_BITS-1:0] q_open, q_low, q_high, q_close;
    logic [lom_pkg::AMT_W-1:0] vol_total;
    beat_t          expected_beats[$];
    int             errors;

    function new();
      n_sell = 0;
      n_buy = 0;
      foreach (rub_tbl[i]) rub_tbl[i] = '0;
      foreach (usd_tbl[i]) usd_tbl[i] = '0;
      q_open = '0;
      q_low = '0;
      q_high = '0;
      q_close = '0;
      vol_total = '0;
      errors = 0;
    endfunction

    function void add_expected(beat_t b);
      expected_beats.insert(expected_beats.size(), b);
    endfunction

    function void drop_sell(int idx);
      for (int i = idx; i + 1 < n_sell; i++) sells[i] = sells[i + 1];
      n_sell--;
    endfunction

    function void drop_buy(int idx);
      for (int i = idx; i + 1 < n_buy; i++) buys[i] = buys[i + 1];
      n_buy--;
    endfunction

    function void cross_books();
      int    trades;
      int    bi, si;
      logic [lom_pkg::PRICE_BITS-1:0] best, lowest;
      bit    have_b, have_s;
      logic [lom_pkg::VOLUME_BITS-1:0] v;
      logic [lom_pkg::RUB_W-1:0] cost;
      logic [lom_pkg::USER_W-1:0] su, bu;
      beat_t t;
      trades = 0;
      while (trades + 1 < lom_pkg::MAX_RESULTS) begin
        bi = 0; si = 0; best = '0; lowest = '0;
        have_b = 0; have_s = 0;
        for (int i = 0; i < n_buy; i++)
          if (buys[i].price > best) begin
            best = buys[i].price;
            bi = i;
            have_b = 1;
          end
        if (!have_b) break;
        // own sells of the best buyer are skipped
        for (int i = 0; i < n_sell; i++)
          if (sells[i].user != buys[bi].user && (!have_s || sells[i].price < lowest)) begin
            lowest = sells[i].price;
            si = i;
            have_s = 1;
          end
        if (!have_s || lowest > best) break;
        v = (buys[bi].vol < sells[si].vol) ? buys[bi].vol : sells[si].vol;
        cost = lom_pkg::RUB_W'(v) * lom_pkg::RUB_W'(best);
        su = sells[si].user;
        bu = buys[bi].user;
        sells[si].vol -= v;
        buys[bi].vol -= v;
        rub_tbl[su] = rub_tbl[su] + cost;
        usd_tbl[su] = usd_tbl[su] - lom_pkg::USD_W'(v);
        rub_tbl[bu] = rub_tbl[bu] - cost;
        usd_tbl[bu] = usd_tbl[bu] + lom_pkg::USD_W'(v);
        if (q_open == '0) begin
          q_open = best; q_low = best; q_high = best; q_close = best;
          vol_total = lom_pkg::AMT_W'(v);
        end else begin
          if (best < q_low) q_low = best;
          if (best > q_high) q_high = best;
          q_close = best;
          vol_total = vol_total + lom_pkg::AMT_W'(v);
        end
        t = '0;
        t.kind = lom_pkg::KIND_TRADE;
        t.seller = su;
        t.buyer = bu;
        t.amount = lom_pkg::AMT_W'(v);
        t.price = best;
        add_expected(t);
        trades++;
        if (buys[bi].vol == '0) drop_buy(bi);
        if (sells[si].vol == '0) drop_sell(si);
        if (n_sell == 0) break;
      end
    endfunction

    function void note_order(logic side, order_t o);
      int    number;
      int    other;
      logic  st;
      beat_t a;
      number = (side == lom_pkg::SIDE_BUY) ? n_buy : n_sell;
      other = (side == lom_pkg::SIDE_BUY) ? n_sell : n_buy;
      st = lom_pkg::ST_OK;
      if (number >= DEPTH) begin
        st = lom_pkg::ST_FULL;
      end else begin
        if (side == lom_pkg::SIDE_BUY) begin
          buys[n_buy] = o;
          n_buy++;
        end else begin
          sells[n_sell] = o;
          n_sell++;
        end
        if (other != 0) cross_books();
      end
      a = '0;
      a.kind = lom_pkg::KIND_ACK;
      a.amount = vol_total;
      a.price = q_open;
      a.number = lom_pkg::NUM_W'(number);
      a.status = st;
      a.rub = rub_tbl[o.user];
      a.usd = usd_tbl[o.user];
      a.low = q_low;
      a.high = q_high;
      a.last = 1'b1;
      add_expected(a);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_beat(beat_t got);
      beat_t e;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat %p", got));
        return;
      end
      e = expected_beats.pop_front();
      if (got.kind !== e.kind || got.seller !== e.seller || got.buyer !== e.buyer ||
          got.amount !== e.amount || got.price !== e.price ||
          got.number !== e.number || got.status !== e.status ||
          got.rub !== e.rub || got.usd !== e.usd || got.low !== e.low ||
          got.high !== e.high || got.last !== e.last)
        report($sformatf("got %p exp %p", got, e));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [lom_pkg::USER_W-1:0] in_trader = '0;
  logic [15:0] in_quantity = '0;
  logic [15:0] in_limit_price = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [lom_pkg::USER_W-1:0] out_seller_user, out_buyer_user;
  logic [lom_pkg::AMT_W-1:0] out_trade_amount;
  logic [lom_pkg::PRICE_BITS-1:0] out_trade_price;
  logic [lom_pkg::NUM_W-1:0] out_order_number;
  logic out_status;
  logic signed [lom_pkg::RUB_W-1:0] out_rub_balance;
  logic signed [lom_pkg::USD_W-1:0] out_usd_balance;
  logic [lom_pkg::PRICE_BITS-1:0] out_session_low, out_session_high;
  logic out_last;

  match_scoreboard sb = new();
  int  phase = 0;      // 0: sender idles rarely, 1: receiver idles rarely, 2: none
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  cycles = 0;

  limit_order_matcher_top i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_trader,
    .in_quantity, .in_limit_price, .out_valid, .out_ready, .out_kind,
    .out_seller_user, .out_buyer_user, .out_trade_amount, .out_trade_price,
    .out_order_number, .out_status, .out_rub_balance, .out_usd_balance,
    .out_session_low, .out_session_high, .out_last
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_beat({out_kind, out_seller_user, out_buyer_user, out_trade_amount,
                     out_trade_price, out_order_number, out_status,
                     out_rub_balance, out_usd_balance, out_session_low,
                     out_session_high, out_last});
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (phase == 0) begin
      out_ready <= ($urandom_range(0, 99) >= 77);
    end else if (phase == 1) begin
      out_ready <= ($urandom_range(0, 99) >= 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_order(logic side, logic [7:0] user, logic [15:0] qty,
                            logic [15:0] price);
    int gap;
    in_valid <= 1'b1;
    in_req_type <= side;
    in_trader <= user;
    in_quantity <= qty;
    in_limit_price <= price;
    do @(posedge clk); while (!in_ready);
    sb.note_order(side, '{user: user, vol: qty, price: price});
    gap = 0;
    if (phase == 0 && $urandom_range(0, 99) < 6) gap = $urandom_range(1, 6);
    if (phase == 1 && $urandom_range(0, 99) < 77) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_order();
    if ($urandom_range(0, 9) < 9) begin
      // crossing-range order among a few traders
      send_order(1'($urandom_range(0, 1)),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)),
                 16'($urandom_range(0, 2000)), 16'($urandom_range(95, 105)));
    end else begin
      send_order(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // simple cross, zero-priced buy, own sells only, zero-volume sell
    send_order(lom_pkg::SIDE_SELL, 8'd1, 16'd100, 16'd50);
    send_order(lom_pkg::SIDE_BUY, 8'd2, 16'd60, 16'd60);
    send_order(lom_pkg::SIDE_BUY, 8'd3, 16'd0, 16'd0);
    send_order(lom_pkg::SIDE_SELL, 8'd4, 16'd10, 16'd30);
    send_order(lom_pkg::SIDE_BUY, 8'd4, 16'd10, 16'd40);
    send_order(lom_pkg::SIDE_SELL, 8'd5, 16'd0, 16'd1);
    // field extremes
    send_order(lom_pkg::SIDE_BUY, 8'd255, 16'hFFFF, 16'hFFFF);
    send_order(lom_pkg::SIDE_SELL, 8'd0, 16'hFFFF, 16'd0);
    // fill the sell book past full, then sweep it with one big buy
    for (int i = 0; i < 17; i++) send_order(lom_pkg::SIDE_SELL, 8'd7, 16'd4096, 16'd60000);
    send_order(lom_pkg::SIDE_BUY, 8'd9, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) phase = 1;
      if (i == 2 * N_RANDOM / 3) begin
        phase = 2;
        hold_req = 1;
      end
      random_order();
    end
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
